/* sv/pcet_pkg.sv */
// Shared constants, types and codes of the pack cell extrema tracker.
`default_nettype none
package pcet_pkg;

   // Pack geometry.
   localparam int unsigned BOARDS                  = 16;
   localparam int unsigned VOLT_CHANNELS           = 16;
   localparam int unsigned TEMP_CHANNELS_PER_BOARD = 16;

   // Queue between the classifier and the tracker.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Register reset values.
   localparam logic       IGNORE_ENABLE_RESET = 1'b1;
   localparam logic [7:0] IGNORED_SLOT_RESET  = 8'd143;

   // Tracker reset values.
   localparam logic [15:0]        MIN_VOLT_RESET = 16'hFFFF;
   localparam logic [15:0]        MAX_VOLT_RESET = 16'h0000;
   localparam logic signed [15:0] MIN_TEMP_RESET = 16'sh7FFF;
   localparam logic signed [15:0] MAX_TEMP_RESET = 16'sh8000;
   localparam logic [23:0]        TOTAL_MAX      = 24'hFFFFFF;

   // Configuration register indexes.
   typedef enum logic {
      CSR_IGNORE_ENABLE = 1'b0,
      CSR_IGNORED_SLOT  = 1'b1
   } csr_index_type;

   // Summary result kinds, in emission order.
   typedef enum logic [2:0] {
      KIND_MIN_VOLT = 3'd0,
      KIND_MAX_VOLT = 3'd1,
      KIND_MIN_TEMP = 3'd2,
      KIND_MAX_TEMP = 3'd3,
      KIND_TOTAL    = 3'd4
   } kind_type;

   // A classified reading as it travels through the queue.
   typedef struct packed {
      logic               volt_use;
      logic               temp_use;
      logic               last;
      logic [3:0]         board;
      logic [3:0]         channel;
      logic [15:0]        voltage_mv;
      logic signed [15:0] temperature;
   } item_type;

   // Queue status seen by the classifier.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

/* sv/pack_cell_extrema_tracker_core.sv */
// Top level of the pack cell extrema tracker: classifier, queue and tracker.
// Throughput: one reading per cycle unless the queue is full; a last reading waits until
// the previous summary drains. A reading accepted into the queue is registered there and
// folded into the tracker state when it leaves the queue; the first summary item of a last
// reading is offered on the cycle after that reading leaves the queue, and a summary is five items.
// Reset (synchronous, active high) empties the queue, restores the extremes and registers.
`default_nettype none
module pack_cell_extrema_tracker_core (
   input  wire logic                clock,
   input  wire logic                reset,
   // Reading channel.
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_mode,
   input  wire logic [3:0]          req_board,
   input  wire logic [3:0]          req_channel,
   input  wire logic [15:0]         req_voltage_mv,
   input  wire logic signed [15:0]  req_temperature,
   input  wire logic                req_last,
   // Summary channel.
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_kind,
   output logic signed [24:0]       rsp_value,
   output logic [3:0]               rsp_where_board,
   output logic [3:0]               rsp_where_channel,
   output logic                     rsp_last_of_run,
   // Configuration write port.
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [7:0]          csr_wdata
);

   // The classifier pushes every accepted item into the queue, tagged with
   // whether it counts as a voltage, counts as a temperature, or neither.
   pcet_pkg::queue_status_type queue_status;
   pcet_pkg::item_type         push_item;
   pcet_pkg::item_type         head_item;
   logic                       push_valid;
   logic                       pop;

   pcet_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_board       (req_board),
      .req_channel     (req_channel),
      .req_voltage_mv  (req_voltage_mv),
      .req_temperature (req_temperature),
      .req_last        (req_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .queue_status    (queue_status),
      .push_valid      (push_valid),
      .push_item       (push_item)
   );

   // The queue lets the input keep flowing while a last reading waits at its head for
   // the previous summary to drain, and stalls the input once all four of its entries are held.
   pcet_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_item    (push_item),
      .pop          (pop),
      .head_item    (head_item),
      .queue_status (queue_status)
   );

   // The tracker folds one queued item per cycle into the running extremes, a last item only
   // once the previous summary is out. It then snapshots the folded result, clears its state
   // and plays the snapshot out as five summary items while later readings keep folding in.
   pcet_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_item         (head_item),
      .head_valid        (!queue_status.empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_where_board   (rsp_where_board),
      .rsp_where_channel (rsp_where_channel),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
`default_nettype wire

/* sv/pcet_front.sv */
// Input classifier: holds the configuration registers and tags each reading.
`default_nettype none
module pcet_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_mode,
   input  wire logic [3:0]                 req_board,
   input  wire logic [3:0]                 req_channel,
   input  wire logic [15:0]                req_voltage_mv,
   input  wire logic signed [15:0]         req_temperature,
   input  wire logic                       req_last,
   input  wire logic                       csr_wr_en,
   input  wire logic                       csr_index,
   input  wire logic [7:0]                 csr_wdata,
   input  wire pcet_pkg::queue_status_type queue_status,
   output logic                            push_valid,
   output pcet_pkg::item_type              push_item
);

   logic       ignore_enable_ff;
   logic       ignore_enable_in;
   logic [7:0] ignored_slot_ff;
   logic [7:0] ignored_slot_in;

   logic       board_ok;
   logic       volt_chan_ok;
   logic       temp_chan_ok;
   logic [7:0] slot;
   logic       skip;

   always_comb begin
      ignore_enable_in = ignore_enable_ff;
      ignored_slot_in  = ignored_slot_ff;
      if (csr_wr_en) begin
         case (pcet_pkg::csr_index_type'(csr_index))
            pcet_pkg::CSR_IGNORE_ENABLE: ignore_enable_in = csr_wdata[0];
            pcet_pkg::CSR_IGNORED_SLOT:  ignored_slot_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_enable_ff <= pcet_pkg::IGNORE_ENABLE_RESET;
         ignored_slot_ff  <= pcet_pkg::IGNORED_SLOT_RESET;
      end else begin
         ignore_enable_ff <= ignore_enable_in;
         ignored_slot_ff  <= ignored_slot_in;
      end
   end

   // Readings from boards or channels outside the pack take part in nothing.
   assign board_ok     = {1'b0, req_board} < 5'(pcet_pkg::BOARDS);
   assign volt_chan_ok = {1'b0, req_channel} < 5'(pcet_pkg::VOLT_CHANNELS);
   assign temp_chan_ok = {1'b0, req_channel} < 5'(pcet_pkg::TEMP_CHANNELS_PER_BOARD);
   assign slot = 8'(req_board) * 8'(pcet_pkg::TEMP_CHANNELS_PER_BOARD) + 8'(req_channel);
   assign skip = ignore_enable_ff && (slot == ignored_slot_ff);

   assign req_stall  = queue_status.full;
   assign push_valid = req_valid && !queue_status.full;

   always_comb begin
      push_item.volt_use    = board_ok && !req_mode && volt_chan_ok;
      push_item.temp_use    = board_ok && req_mode && temp_chan_ok && !skip;
      push_item.last        = req_last;
      push_item.board       = req_board;
      push_item.channel     = req_channel;
      push_item.voltage_mv  = req_voltage_mv;
      push_item.temperature = req_temperature;
   end

endmodule
`default_nettype wire

/* sv/pcet_queue.sv */
// Short FIFO of classified readings between the classifier and the tracker.
`default_nettype none
module pcet_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire pcet_pkg::item_type         push_item,
   input  wire logic                       pop,
   output pcet_pkg::item_type              head_item,
   output pcet_pkg::queue_status_type      queue_status
);

   pcet_pkg::item_type                entries_ff [pcet_pkg::QUEUE_DEPTH];
   logic [pcet_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [pcet_pkg::QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [pcet_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [pcet_pkg::QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [pcet_pkg::QUEUE_PTR_W:0]    count_ff;
   logic [pcet_pkg::QUEUE_PTR_W:0]    count_in;
   logic                              do_pop;

   assign queue_status.full  = (count_ff == (pcet_pkg::QUEUE_PTR_W+1)'(pcet_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head_item = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && !queue_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == pcet_pkg::QUEUE_PTR_W'(pcet_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pcet_pkg::QUEUE_PTR_W'(pcet_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (pcet_pkg::QUEUE_PTR_W+1)'(pcet_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push_valid)
      else $error("push into full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> !pop)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* sv/pcet_back.sv */
// Tracker: folds readings into the running extremes and emits the summary.
`default_nettype none
module pcet_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcet_pkg::item_type    head_item,
   input  wire logic                  head_valid,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_kind,
   output logic signed [24:0]         rsp_value,
   output logic [3:0]                 rsp_where_board,
   output logic [3:0]                 rsp_where_channel,
   output logic                       rsp_last_of_run
);

   // Running state.
   logic [15:0]        min_volt_ff,  min_volt_in;
   logic [15:0]        max_volt_ff,  max_volt_in;
   logic signed [15:0] min_temp_ff,  min_temp_in;
   logic signed [15:0] max_temp_ff,  max_temp_in;
   logic [7:0]         loc_ff [4];
   logic [7:0]         loc_in [4];
   logic [23:0]        total_ff,     total_in;

   // Summary snapshot.
   logic [15:0]        snap_min_volt_ff;
   logic [15:0]        snap_max_volt_ff;
   logic signed [15:0] snap_min_temp_ff;
   logic signed [15:0] snap_max_temp_ff;
   logic [7:0]         snap_loc_ff [4];
   logic [23:0]        snap_total_ff;

   // Emitter.
   logic               busy_ff, busy_in;
   pcet_pkg::kind_type kind_ff, kind_in;

   // Folded values.
   logic [15:0]        f_min_volt, f_max_volt;
   logic signed [15:0] f_min_temp, f_max_temp;
   logic [7:0]         f_loc [4];
   logic [24:0]        sum;
   logic [23:0]        f_total;
   logic [7:0]         item_loc;
   logic               take_last;
   logic               beat_done;

   assign item_loc = {head_item.board, head_item.channel};

   always_comb begin
      f_min_volt = min_volt_ff;
      f_max_volt = max_volt_ff;
      f_min_temp = min_temp_ff;
      f_max_temp = max_temp_ff;
      f_loc[0]   = loc_ff[0];
      f_loc[1]   = loc_ff[1];
      f_loc[2]   = loc_ff[2];
      f_loc[3]   = loc_ff[3];
      f_total    = total_ff;
      sum        = 25'(total_ff) + 25'(head_item.voltage_mv);
      if (head_item.volt_use) begin
         if (head_item.voltage_mv < min_volt_ff) begin
            f_min_volt = head_item.voltage_mv;
            f_loc[0]   = item_loc;
         end
         if (head_item.voltage_mv > max_volt_ff) begin
            f_max_volt = head_item.voltage_mv;
            f_loc[1]   = item_loc;
         end
         f_total = sum[24] ? pcet_pkg::TOTAL_MAX : sum[23:0];
      end
      if (head_item.temp_use) begin
         if (head_item.temperature < min_temp_ff) begin
            f_min_temp = head_item.temperature;
            f_loc[2]   = item_loc;
         end
         if (head_item.temperature > max_temp_ff) begin
            f_max_temp = head_item.temperature;
            f_loc[3]   = item_loc;
         end
      end
   end

   // A last reading waits until the previous summary has fully drained.
   assign pop       = head_valid && (!head_item.last || !busy_ff);
   assign take_last = pop && head_item.last;
   assign beat_done = busy_ff && !rsp_stall;

   always_comb begin
      min_volt_in = min_volt_ff;
      max_volt_in = max_volt_ff;
      min_temp_in = min_temp_ff;
      max_temp_in = max_temp_ff;
      loc_in[0]   = loc_ff[0];
      loc_in[1]   = loc_ff[1];
      loc_in[2]   = loc_ff[2];
      loc_in[3]   = loc_ff[3];
      total_in    = total_ff;
      if (take_last) begin
         min_volt_in = pcet_pkg::MIN_VOLT_RESET;
         max_volt_in = pcet_pkg::MAX_VOLT_RESET;
         min_temp_in = pcet_pkg::MIN_TEMP_RESET;
         max_temp_in = pcet_pkg::MAX_TEMP_RESET;
         loc_in[0]   = '0;
         loc_in[1]   = '0;
         loc_in[2]   = '0;
         loc_in[3]   = '0;
         total_in    = '0;
      end else if (pop) begin
         min_volt_in = f_min_volt;
         max_volt_in = f_max_volt;
         min_temp_in = f_min_temp;
         max_temp_in = f_max_temp;
         loc_in[0]   = f_loc[0];
         loc_in[1]   = f_loc[1];
         loc_in[2]   = f_loc[2];
         loc_in[3]   = f_loc[3];
         total_in    = f_total;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      if (take_last) begin
         busy_in = 1'b1;
         kind_in = pcet_pkg::KIND_MIN_VOLT;
      end else if (beat_done) begin
         if (kind_ff == pcet_pkg::KIND_TOTAL) begin
            busy_in = 1'b0;
         end else begin
            kind_in = pcet_pkg::kind_type'(kind_ff + 3'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_volt_ff <= pcet_pkg::MIN_VOLT_RESET;
         max_volt_ff <= pcet_pkg::MAX_VOLT_RESET;
         min_temp_ff <= pcet_pkg::MIN_TEMP_RESET;
         max_temp_ff <= pcet_pkg::MAX_TEMP_RESET;
         loc_ff[0]   <= '0;
         loc_ff[1]   <= '0;
         loc_ff[2]   <= '0;
         loc_ff[3]   <= '0;
         total_ff    <= '0;
         busy_ff     <= 1'b0;
         kind_ff     <= pcet_pkg::KIND_MIN_VOLT;
      end else begin
         min_volt_ff <= min_volt_in;
         max_volt_ff <= max_volt_in;
         min_temp_ff <= min_temp_in;
         max_temp_ff <= max_temp_in;
         loc_ff[0]   <= loc_in[0];
         loc_ff[1]   <= loc_in[1];
         loc_ff[2]   <= loc_in[2];
         loc_ff[3]   <= loc_in[3];
         total_ff    <= total_in;
         busy_ff     <= busy_in;
         kind_ff     <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         snap_min_volt_ff <= f_min_volt;
         snap_max_volt_ff <= f_max_volt;
         snap_min_temp_ff <= f_min_temp;
         snap_max_temp_ff <= f_max_temp;
         snap_loc_ff[0]   <= f_loc[0];
         snap_loc_ff[1]   <= f_loc[1];
         snap_loc_ff[2]   <= f_loc[2];
         snap_loc_ff[3]   <= f_loc[3];
         snap_total_ff    <= f_total;
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_last_of_run = (kind_ff == pcet_pkg::KIND_TOTAL);

   always_comb begin
      case (kind_ff)
         pcet_pkg::KIND_MIN_VOLT: begin
            rsp_value         = signed'({9'd0, snap_min_volt_ff});
            rsp_where_board   = snap_loc_ff[0][7:4];
            rsp_where_channel = snap_loc_ff[0][3:0];
         end
         pcet_pkg::KIND_MAX_VOLT: begin
            rsp_value         = signed'({9'd0, snap_max_volt_ff});
            rsp_where_board   = snap_loc_ff[1][7:4];
            rsp_where_channel = snap_loc_ff[1][3:0];
         end
         pcet_pkg::KIND_MIN_TEMP: begin
            rsp_value         = 25'(snap_min_temp_ff);
            rsp_where_board   = snap_loc_ff[2][7:4];
            rsp_where_channel = snap_loc_ff[2][3:0];
         end
         pcet_pkg::KIND_MAX_TEMP: begin
            rsp_value         = 25'(snap_max_temp_ff);
            rsp_where_board   = snap_loc_ff[3][7:4];
            rsp_where_channel = snap_loc_ff[3][3:0];
         end
         pcet_pkg::KIND_TOTAL: begin
            rsp_value         = signed'({1'b0, snap_total_ff});
            rsp_where_board   = '0;
            rsp_where_channel = '0;
         end
         default: begin
            rsp_value         = '0;
            rsp_where_board   = '0;
            rsp_where_channel = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_last_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      take_last |-> !busy_ff)
      else $error("summary started while previous one still draining");
   a_summary_starts: assert property (@(posedge clock) disable iff (reset)
      take_last |=> busy_ff && kind_ff == pcet_pkg::KIND_MIN_VOLT)
      else $error("summary did not start with minimum voltage");
   a_kind_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> kind_ff <= pcet_pkg::KIND_TOTAL)
      else $error("summary kind out of range");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      beat_done && kind_ff == pcet_pkg::KIND_TOTAL && !take_last |=> !busy_ff)
      else $error("emitter did not stop after the total");
   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      take_last |=> total_ff == '0 && min_volt_ff == pcet_pkg::MIN_VOLT_RESET)
      else $error("tracker state not cleared after summary");
`endif

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the pack cell extrema tracker top level.
`timescale 1ns / 1ps
module tb_top;

   // The clock period is 12 ns, and reset is held from the start. If no item moves on
   // either channel and no register is written until the quiet count reaches WATCHDOG_LIMIT,
   // the run is declared hung. The longest quiet stretch in a correct run is the settle wait,
   // plus a sender gap, plus a receiver stall. That stretch stays far below the limit.
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   // One expected summary item, with the fields in port order.
   typedef struct {
      pcet_pkg::kind_type kind;
      logic signed [24:0] value;
      logic [3:0]         board;
      logic [3:0]         channel;
      logic               last_of_run;
   } summary_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_mode        = 1'b0;
   logic [3:0]         req_board       = 4'd0;
   logic [3:0]         req_channel     = 4'd0;
   logic [15:0]        req_voltage_mv  = 16'd0;
   logic signed [15:0] req_temperature = 16'sd0;
   logic               req_last        = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_kind;
   logic signed [24:0] rsp_value;
   logic [3:0]         rsp_where_board;
   logic [3:0]         rsp_where_channel;
   logic               rsp_last_of_run;

   logic               csr_wr_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [7:0]         csr_wdata = 8'd0;

   // Random idling on both channels is enabled while this flag is set.
   bit gaps_on = 1'b1;

   int error_count  = 0;
   int quiet_cycles = 0;
   int stall_left   = 0;

   // The bench keeps its own copy of the register values.
   logic       skip_enable = pcet_pkg::IGNORE_ENABLE_RESET;
   logic [7:0] skip_slot   = pcet_pkg::IGNORED_SLOT_RESET;

   // The running extrema, their locations and the pack total, as the block should hold them.
   logic [15:0]        low_volt     = pcet_pkg::MIN_VOLT_RESET;
   logic [15:0]        high_volt    = pcet_pkg::MAX_VOLT_RESET;
   logic signed [15:0] low_temp     = pcet_pkg::MIN_TEMP_RESET;
   logic signed [15:0] high_temp    = pcet_pkg::MAX_TEMP_RESET;
   logic [7:0]         low_volt_at  = 8'd0;
   logic [7:0]         high_volt_at = 8'd0;
   logic [7:0]         low_temp_at  = 8'd0;
   logic [7:0]         high_temp_at = 8'd0;
   logic [23:0]        pack_total   = 24'd0;

   summary_item_type pending_summaries[$];

   pack_cell_extrema_tracker_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_board         (req_board),
      .req_channel       (req_channel),
      .req_voltage_mv    (req_voltage_mv),
      .req_temperature   (req_temperature),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_value         (rsp_value),
      .rsp_where_board   (rsp_where_board),
      .rsp_where_channel (rsp_where_channel),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // Folds one accepted reading into the running extrema. Compares are strict, so the
   // first reading in scan order keeps a tie. On a last reading, five summary items are
   // queued and the extrema return to their reset values. The registers are kept.
   function void fold_reading(input logic mode, input logic [3:0] board,
                              input logic [3:0] channel, input logic [15:0] volt,
                              input logic signed [15:0] temp, input logic last);
      logic [7:0]  loc;
      logic [24:0] widened;
      int          slot;
      loc  = {board, channel};
      slot = int'(board) * pcet_pkg::TEMP_CHANNELS_PER_BOARD + int'(channel);
      if (board < pcet_pkg::BOARDS) begin
         if (!mode && channel < pcet_pkg::VOLT_CHANNELS) begin
            if (volt < low_volt) begin
               low_volt    = volt;
               low_volt_at = loc;
            end
            if (volt > high_volt) begin
               high_volt    = volt;
               high_volt_at = loc;
            end
            // The pack total saturates instead of wrapping.
            widened    = {1'b0, pack_total} + {9'd0, volt};
            pack_total = (widened > {1'b0, pcet_pkg::TOTAL_MAX}) ?
                         pcet_pkg::TOTAL_MAX : widened[23:0];
         end else if (mode && channel < pcet_pkg::TEMP_CHANNELS_PER_BOARD) begin
            // A reading from the broken thermistor takes part in no compare while the skip is enabled.
            if (!(skip_enable && slot == int'(skip_slot))) begin
               if (temp < low_temp) begin
                  low_temp    = temp;
                  low_temp_at = loc;
               end
               if (temp > high_temp) begin
                  high_temp    = temp;
                  high_temp_at = loc;
               end
            end
         end
      end
      if (last) begin
         pending_summaries.push_back('{pcet_pkg::KIND_MIN_VOLT, {9'd0, low_volt},
                                       low_volt_at[7:4], low_volt_at[3:0], 1'b0});
         pending_summaries.push_back('{pcet_pkg::KIND_MAX_VOLT, {9'd0, high_volt},
                                       high_volt_at[7:4], high_volt_at[3:0], 1'b0});
         pending_summaries.push_back('{pcet_pkg::KIND_MIN_TEMP,
                                       {{9{low_temp[15]}}, low_temp},
                                       low_temp_at[7:4], low_temp_at[3:0], 1'b0});
         pending_summaries.push_back('{pcet_pkg::KIND_MAX_TEMP,
                                       {{9{high_temp[15]}}, high_temp},
                                       high_temp_at[7:4], high_temp_at[3:0], 1'b0});
         pending_summaries.push_back('{pcet_pkg::KIND_TOTAL, {1'b0, pack_total},
                                       4'd0, 4'd0, 1'b1});
         low_volt     = pcet_pkg::MIN_VOLT_RESET;
         high_volt    = pcet_pkg::MAX_VOLT_RESET;
         low_temp     = pcet_pkg::MIN_TEMP_RESET;
         high_temp    = pcet_pkg::MAX_TEMP_RESET;
         low_volt_at  = 8'd0;
         high_volt_at = 8'd0;
         low_temp_at  = 8'd0;
         high_temp_at = 8'd0;
         pack_total   = 24'd0;
      end
   endfunction

   // Offers one reading and returns at the edge where it is accepted. The valid signal
   // stays high on return, so back-to-back items go without a gap. A random gap can
   // be inserted before the reading.
   task send_reading(input logic mode, input logic [3:0] board, input logic [3:0] channel,
                     input logic [15:0] volt, input logic signed [15:0] temp,
                     input logic last);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_board       <= board;
      req_channel     <= channel;
      req_voltage_mv  <= volt;
      req_temperature <= temp;
      req_last        <= last;
      do @(posedge clock); while (req_stall);
      fold_reading(mode, board, channel, volt, temp, last);
   endtask

   // Lowers valid and waits until every queued summary item has been checked. The loop
   // always waits on the clock before it tests, so valid is never lowered and raised in one step.
   task wait_for_summaries();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_summaries.size() != 0);
   endtask

   // Readings that cause no summary may still be in flight. Let them settle before the
   // registers change.
   task wait_until_idle();
      wait_for_summaries();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the enable, then the slot, on back-to-back edges with csr_wr_en held high.
   task write_config(input logic enable, input logic [7:0] slot);
      csr_wr_en <= 1'b1;
      csr_index <= pcet_pkg::CSR_IGNORE_ENABLE;
      csr_wdata <= {7'd0, enable};
      @(posedge clock);
      skip_enable = enable;
      csr_index <= pcet_pkg::CSR_IGNORED_SLOT;
      csr_wdata <= slot;
      @(posedge clock);
      skip_slot = slot;
      csr_wr_en <= 1'b0;
   endtask

   // A scan that accepts no temperature reports the reset extremes at location 0.
   // The same holds for a voltage reading that only ties the reset value.
   task test_no_accepted_readings();
      send_reading(1'b1, 4'd8, 4'd15, 16'h1234, -16'sd1, 1'b1);
      send_reading(1'b0, 4'd0, 4'd0, 16'd0, 16'sd0, 1'b1);
   endtask

   // This test covers the voltage extremes. A tie keeps the first location. A reading of
   // 65535 cannot become the minimum, and a reading of 0 cannot become the maximum.
   task test_voltage_extremes();
      send_reading(1'b0, 4'd0, 4'd3, 16'hFFFF, 16'sd0, 1'b0);
      send_reading(1'b0, 4'd1, 4'd2, 16'd100, 16'sd0, 1'b0);
      send_reading(1'b0, 4'd3, 4'd4, 16'd100, 16'sd0, 1'b0);
      send_reading(1'b0, 4'd5, 4'd6, 16'd0, 16'sd0, 1'b0);
      send_reading(1'b0, 4'd7, 4'd8, 16'hFFFF, 16'sd0, 1'b0);
      send_reading(1'b0, 4'd9, 4'd0, 16'd0, 16'sd0, 1'b0);
      send_reading(1'b1, 4'd15, 4'd15, 16'd0, 16'sh7FFF, 1'b1);
   endtask

   // This test covers the signed temperature extremes, with a tie and a skipped reading
   // from the broken slot.
   task test_temperature_extremes();
      send_reading(1'b1, 4'd0, 4'd1, 16'd0, -16'sd32768, 1'b0);
      send_reading(1'b1, 4'd2, 4'd3, 16'd0, -16'sd5, 1'b0);
      send_reading(1'b1, 4'd4, 4'd5, 16'd0, -16'sd5, 1'b0);
      send_reading(1'b1, 4'd8, 4'd15, 16'd0, 16'sh7FFF, 1'b0);
      send_reading(1'b1, 4'd9, 4'd0, 16'd0, 16'sd10, 1'b0);
      send_reading(1'b0, 4'd15, 4'd15, 16'hFFFF, 16'sd0, 1'b1);
   endtask

   // The skip can be disabled, and it can point at the first and the last slot.
   task test_broken_thermistor_slot();
      wait_until_idle();
      write_config(1'b0, 8'd143);
      send_reading(1'b1, 4'd8, 4'd15, 16'd0, -16'sd100, 1'b1);
      wait_until_idle();
      write_config(1'b1, 8'd0);
      send_reading(1'b1, 4'd0, 4'd0, 16'd0, -16'sd7, 1'b0);
      send_reading(1'b1, 4'd15, 4'd15, 16'd0, 16'sd7, 1'b1);
      wait_until_idle();
      write_config(1'b1, 8'd255);
      send_reading(1'b1, 4'd15, 4'd15, 16'd0, 16'sd3, 1'b0);
      send_reading(1'b1, 4'd0, 4'd0, 16'd0, -16'sd3, 1'b1);
   endtask

   // This scan sends 260 full-scale cells, which drives the 24-bit total into saturation.
   task test_total_saturation();
      for (int i = 0; i < 260; i++)
         send_reading(1'b0, 4'((i / 16) % 16), 4'(i % 16), 16'hFFFF,
                      16'($urandom), i == 259);
   endtask

   // Sends one random scan and returns its length. Most scans follow board-major order.
   // Some are noise with boards in any order. Values are biased toward the extremes
   // and toward narrow bands that produce ties.
   task send_random_scan(output int length);
      logic               mode;
      logic [3:0]         board;
      logic [3:0]         channel;
      logic [15:0]        volt;
      logic signed [15:0] temp;
      int                 cur_board;
      bit                 noisy;
      length    = $urandom_range(1, 12);
      noisy     = ($urandom_range(0, 7) == 0);
      cur_board = $urandom_range(0, 4);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 2) == 0 && cur_board < 15)
            cur_board++;
         board   = noisy ? 4'($urandom) : 4'(cur_board);
         channel = 4'($urandom);
         mode    = 1'($urandom);
         // Now and then the reading lands on the broken slot.
         if ($urandom_range(0, 9) == 0)
            {board, channel} = skip_slot;
         case ($urandom_range(0, 7))
            0:       volt = 16'd0;
            1:       volt = 16'hFFFF;
            2, 3:    volt = 16'($urandom_range(3300, 3304));
            default: volt = 16'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       temp = -16'sd32768;
            1:       temp = 16'sh7FFF;
            2, 3:    temp = 16'(int'($urandom_range(0, 8)) - 4);
            default: temp = 16'($urandom);
         endcase
         send_reading(mode, board, channel, volt, temp, i == length - 1);
      end
   endtask

   // The random scans run in four register settings. In the second setting, the sender
   // once holds off until all summaries have drained. The last setting runs with no idling.
   task test_random_scans();
      int sent;
      int length;
      for (int phase = 0; phase < 4; phase++) begin
         wait_until_idle();
         case (phase)
            0:       write_config(1'b1, 8'($urandom));
            1:       write_config(1'b0, skip_slot);
            2:       write_config(1'b1, 8'd255);
            default: begin
               write_config(1'b1, 8'd0);
               gaps_on = 1'b0;
            end
         endcase
         sent = 0;
         while (sent < 40) begin
            send_random_scan(length);
            sent += length;
            if (phase == 1 && sent >= 20 && sent - length < 20)
               wait_for_summaries();
         end
      end
   endtask

   task report_field(input string name, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Every summary item that is accepted is checked against the oldest expectation.
   always @(posedge clock) begin
      summary_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0) begin
            error_count++;
            $error("unexpected summary item: kind %0d value %0d", rsp_kind, rsp_value);
         end else begin
            want = pending_summaries.pop_front();
            report_field("kind", want.kind, rsp_kind);
            report_field("value", want.value, rsp_value);
            report_field("where_board", want.board, rsp_where_board);
            report_field("where_channel", want.channel, rsp_where_channel);
            report_field("last_of_run", want.last_of_run, rsp_last_of_run);
         end
      end
   end

   // The receiver stalls in random bursts, started only while gaps are on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The watchdog counts cycles in which nothing is accepted and no register is written.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** pack_cell_extrema_tracker_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_no_accepted_readings();
      test_voltage_extremes();
      test_temperature_extremes();
      test_broken_thermistor_slot();
      test_total_saturation();
      test_random_scans();
      wait_for_summaries();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_summaries.size() == 0) begin
         $display("** pack_cell_extrema_tracker_core: PASSED **");
      end else begin
         $display("** pack_cell_extrema_tracker_core: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/pcet_pkg.sv
sv/pcet_front.sv
sv/pcet_queue.sv
sv/pcet_back.sv
sv/pack_cell_extrema_tracker_core.sv
bench/tb_top.sv
